// ===== hw/rtl/etok_pkg.sv =====
`default_nettype none

package etok_pkg;

    localparam int KEYWORD_COUNT = 8;
    localparam int KEYWORD_CHARS = 8;
    localparam int LINE_BITS     = 24;
    localparam int KW_BITS       = 8 * KEYWORD_CHARS;
    localparam int KW_IDX_BITS   = 3;
    localparam int COL_BITS      = 16;
    localparam int LEN_BITS      = 16;
    localparam int KIND_BITS     = 6;

    // token kinds
    localparam logic [KIND_BITS-1:0] K_END     = 6'd0;
    localparam logic [KIND_BITS-1:0] K_ERROR   = 6'd1;
    localparam logic [KIND_BITS-1:0] K_INTEGER = 6'd2;
    localparam logic [KIND_BITS-1:0] K_NUMBER  = 6'd3;
    localparam logic [KIND_BITS-1:0] K_IDENT   = 6'd4;
    localparam logic [KIND_BITS-1:0] K_KEYWORD = 6'd5;
    localparam logic [KIND_BITS-1:0] K_LITERAL = 6'd6;
    localparam logic [KIND_BITS-1:0] K_PLUS    = 6'd7;
    localparam logic [KIND_BITS-1:0] K_MINUS   = 6'd8;
    localparam logic [KIND_BITS-1:0] K_STAR    = 6'd9;
    localparam logic [KIND_BITS-1:0] K_SLASH   = 6'd10;
    localparam logic [KIND_BITS-1:0] K_CARET   = 6'd11;
    localparam logic [KIND_BITS-1:0] K_PIPE    = 6'd12;
    localparam logic [KIND_BITS-1:0] K_AMP     = 6'd13;
    localparam logic [KIND_BITS-1:0] K_BANG    = 6'd14;
    localparam logic [KIND_BITS-1:0] K_EQUAL   = 6'd15;
    localparam logic [KIND_BITS-1:0] K_LPAREN  = 6'd16;
    localparam logic [KIND_BITS-1:0] K_RPAREN  = 6'd17;
    localparam logic [KIND_BITS-1:0] K_LBRACK  = 6'd18;
    localparam logic [KIND_BITS-1:0] K_RBRACK  = 6'd19;
    localparam logic [KIND_BITS-1:0] K_LBRACE  = 6'd20;
    localparam logic [KIND_BITS-1:0] K_RBRACE  = 6'd21;
    localparam logic [KIND_BITS-1:0] K_COMMA   = 6'd22;
    localparam logic [KIND_BITS-1:0] K_SEMI    = 6'd23;
    localparam logic [KIND_BITS-1:0] K_DOT     = 6'd24;
    localparam logic [KIND_BITS-1:0] K_DOTS    = 6'd25;
    localparam logic [KIND_BITS-1:0] K_COLON   = 6'd26;
    localparam logic [KIND_BITS-1:0] K_DEFINE  = 6'd27;
    localparam logic [KIND_BITS-1:0] K_LESS    = 6'd28;
    localparam logic [KIND_BITS-1:0] K_LEQUAL  = 6'd29;
    localparam logic [KIND_BITS-1:0] K_ASSIGN  = 6'd30;
    localparam logic [KIND_BITS-1:0] K_GREATER = 6'd31;
    localparam logic [KIND_BITS-1:0] K_GEQUAL  = 6'd32;

    typedef enum logic [3:0] {
        M_IDLE, M_COMMENT, M_IDENT, M_INT, M_FRAC, M_EXP, M_SIGN, M_EXPD,
        M_DOT, M_COLON, M_LESS, M_GREATER, M_LITERAL
    } scan_mode_t;

    typedef logic [KEYWORD_COUNT-1:0][KW_BITS-1:0] kw_slots_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [LINE_BITS-1:0]   line;
        logic [COL_BITS-1:0]    col;
        logic [LEN_BITS-1:0]    len;
        logic [KW_IDX_BITS-1:0] kw;
        logic                   last;
    } token_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } scan_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/expression_tokenizer.sv =====
// Tokens are registered into the result queue when the byte that closes them is accepted.
// Throughput: one byte per cycle while s_tready is high; a byte that closes a held token
// and emits a second one yields two result beats, drained one per cycle while m_tready
// is high from a four-entry result queue. s_tready drops while the queue could not
// absorb two more beats. Reset (aresetn low, synchronous): scanner idle at line 1,
// column 1, queue empty, keyword slots cleared.
`default_nettype none

module expression_tokenizer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tuser,   // [0] end_of_input
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [5:0] token_kind, [29:6] start_line,
                                        // [45:30] start_column, [61:46] lexeme_length,
                                        // [64:62] keyword_index, rest zero
    output logic             m_tlast,   // last_of_run
    input  wire logic        cfg_wr_en,
    input  wire logic [3:0]  cfg_addr,
    input  wire logic [63:0] cfg_wdata
);
    import etok_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPTR   = $clog2(QDEPTH);

    kw_slots_t  kw_reg;
    scan_out_t  scan;
    logic       in_fire, out_fire;

    token_t             q_mem [QDEPTH];
    logic [QPTR-1:0]    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [QPTR:0]      cnt_reg, cnt_next;
    logic [1:0]         push;
    token_t             head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kw_reg <= '0;
        end else if (cfg_wr_en && cfg_addr < 4'(KEYWORD_COUNT)) begin
            kw_reg[cfg_addr[KW_IDX_BITS-1:0]] <= cfg_wdata;
        end
    end

    assign s_tready = cnt_reg <= (QPTR+1)'(QDEPTH - 2);
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    etok_scan u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_fire      (in_fire),
        .char_code    (s_tdata),
        .end_of_input (s_tuser),
        .keywords     (kw_reg),
        .res          (scan)
    );

    assign push        = in_fire ? scan.count : 2'd0;
    assign wr_ptr_next = wr_ptr_reg + QPTR'(push);
    assign rd_ptr_next = rd_ptr_reg + QPTR'(out_fire);
    assign cnt_next    = cnt_reg + (QPTR+1)'(push) - (QPTR+1)'(out_fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push != 2'd0) begin
            q_mem[wr_ptr_reg] <= scan.tok0;
        end
        if (push == 2'd2) begin
            q_mem[wr_ptr_reg + QPTR'(1)] <= scan.tok1;
        end
    end

    assign head     = q_mem[rd_ptr_reg];
    assign m_tvalid = cnt_reg != '0;
    assign m_tlast  = head.last;
    assign m_tdata  = {7'd0, head.kw, head.len, head.col, head.line, head.kind};

endmodule

`default_nettype wire

// ===== hw/rtl/etok_scan.sv =====
`default_nettype none

module etok_scan (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_fire,
    input  wire logic [7:0]        char_code,
    input  wire logic              end_of_input,
    input  wire etok_pkg::kw_slots_t keywords,
    output etok_pkg::scan_out_t    res
);
    import etok_pkg::*;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    localparam logic [LINE_BITS-1:0] LINE_TOP = '1;

    function automatic logic is_digit(input logic [7:0] ch);
        return ch inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] ch);
        return ch inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic [KIND_BITS-1:0] punct_kind(input logic [7:0] ch);
        logic [KIND_BITS-1:0] k;
        case (ch)
            8'h2B:   k = K_PLUS;
            8'h2D:   k = K_MINUS;
            8'h2A:   k = K_STAR;
            8'h2F:   k = K_SLASH;
            8'h5E:   k = K_CARET;
            8'h7C:   k = K_PIPE;
            8'h26:   k = K_AMP;
            8'h21:   k = K_BANG;
            8'h3D:   k = K_EQUAL;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h5B:   k = K_LBRACK;
            8'h5D:   k = K_RBRACK;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            8'h2C:   k = K_COMMA;
            8'h3B:   k = K_SEMI;
            default: k = K_END;
        endcase
        return k;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [COL_BITS-1:0] sat_add(input logic [COL_BITS-1:0] a,
                                                    input logic [LEN_BITS-1:0] b);
        logic [COL_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COL_BITS] ? '1 : s[COL_BITS-1:0];
    endfunction

    function automatic logic [KW_BITS-1:0] grow_pfx(input logic [KW_BITS-1:0] p,
                                                    input logic [LEN_BITS-1:0] l,
                                                    input logic [7:0] ch);
        logic [KW_BITS-1:0] r;
        r = p;
        if (l < LEN_BITS'(KEYWORD_CHARS)) begin
            r[l[KW_IDX_BITS-1:0]*8 +: 8] = ch;
        end
        return r;
    endfunction

    scan_mode_t            mode_reg, mode_next;
    logic [LINE_BITS-1:0]  line_reg, line_next;
    logic [COL_BITS-1:0]   col_reg, col_next;
    logic [LEN_BITS-1:0]   len_reg, len_next;
    logic [KW_BITS-1:0]    pfx_reg, pfx_next;
    logic                  ended_reg, ended_next;

    logic [7:0]            c;
    logic                  used;
    logic                  a_emit, a_colinc, b_emit;
    logic [KIND_BITS-1:0]  a_kind, b_kind, pk;
    logic [LEN_BITS-1:0]   a_len, b_len;
    logic [KW_IDX_BITS-1:0] a_kw;
    logic [LINE_BITS-1:0]  a_line, b_line;
    logic [COL_BITS-1:0]   a_col, b_col;
    logic                  kw_hit;
    logic [KW_IDX_BITS-1:0] kw_sel;
    logic [7:0]            want;
    logic [KIND_BITS-1:0]  one;

    // keyword compare on the held identifier, lowest slot wins
    always_comb begin
        kw_hit = 1'b0;
        kw_sel = '0;
        if (len_reg <= LEN_BITS'(KEYWORD_CHARS)) begin
            for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
                if (keywords[i] != '0 && keywords[i] == pfx_reg) begin
                    kw_hit = 1'b1;
                    kw_sel = KW_IDX_BITS'(i);
                end
            end
        end
    end

    always_comb begin
        c          = end_of_input ? CH_NUL : char_code;
        mode_next  = mode_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        len_next   = len_reg;
        pfx_next   = pfx_reg;
        ended_next = ended_reg;
        used       = 1'b0;
        a_emit     = 1'b0;
        a_colinc   = 1'b0;
        a_kind     = K_END;
        a_len      = '0;
        a_kw       = '0;
        b_emit     = 1'b0;
        b_kind     = K_END;
        b_len      = '0;
        want       = CH_EQ;
        one        = K_GREATER;
        pk         = punct_kind(c);

        if (ended_reg) begin
            // stream is over: answer every beat with END
            used   = 1'b1;
            a_emit = 1'b1;
        end else begin
            case (mode_reg)
                M_COMMENT: begin
                    if (c != CH_NUL && c != CH_LF) begin
                        a_colinc = 1'b1;
                        used     = 1'b1;
                    end else begin
                        mode_next = M_IDLE;
                    end
                end
                M_IDENT: begin
                    if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
                        pfx_next = grow_pfx(pfx_next, len_next, c);
                        len_next = sat_inc(len_next);
                        used     = 1'b1;
                    end else begin
                        a_emit    = 1'b1;
                        a_kind    = kw_hit ? K_KEYWORD : K_IDENT;
                        a_kw      = kw_hit ? kw_sel : '0;
                        a_len     = len_reg;
                        mode_next = M_IDLE;
                    end
                end
                M_INT, M_FRAC: begin
                    used = 1'b1;
                    if (is_digit(c)) begin
                        len_next = sat_inc(len_next);
                    end else if (c == CH_DOT && mode_reg == M_INT) begin
                        len_next  = sat_inc(len_next);
                        mode_next = M_FRAC;
                    end else if (c == CH_LO_E || c == CH_UP_E) begin
                        len_next  = sat_inc(len_next);
                        mode_next = M_EXP;
                    end else begin
                        used      = 1'b0;
                        a_emit    = 1'b1;
                        a_kind    = (mode_reg == M_INT) ? K_INTEGER : K_NUMBER;
                        a_len     = len_reg;
                        mode_next = M_IDLE;
                    end
                end
                M_EXP, M_SIGN: begin
                    used = 1'b1;
                    if (is_digit(c)) begin
                        len_next  = sat_inc(len_next);
                        mode_next = M_EXPD;
                    end else if (mode_reg == M_EXP && (c == CH_MINUS || c == CH_PLUS)) begin
                        len_next  = sat_inc(len_next);
                        mode_next = M_SIGN;
                    end else begin
                        used      = 1'b0;
                        a_emit    = 1'b1;
                        a_kind    = K_ERROR;
                        a_len     = len_reg;
                        mode_next = M_IDLE;
                    end
                end
                M_EXPD: begin
                    if (is_digit(c)) begin
                        len_next = sat_inc(len_next);
                        used     = 1'b1;
                    end else begin
                        a_emit    = 1'b1;
                        a_kind    = K_NUMBER;
                        a_len     = len_reg;
                        mode_next = M_IDLE;
                    end
                end
                M_DOT, M_COLON, M_GREATER: begin
                    want = (mode_reg == M_DOT) ? CH_DOT : CH_EQ;
                    one  = (mode_reg == M_DOT) ? K_DOT :
                           (mode_reg == M_COLON) ? K_COLON : K_GREATER;
                    a_emit = 1'b1;
                    if (c == want) begin
                        used   = 1'b1;
                        a_kind = one + KIND_BITS'(1);
                        a_len  = sat_inc(len_reg);
                    end else begin
                        a_kind = one;
                        a_len  = len_reg;
                    end
                    mode_next = M_IDLE;
                end
                M_LESS: begin
                    a_emit = 1'b1;
                    if (c == CH_EQ || c == CH_MINUS) begin
                        used   = 1'b1;
                        a_kind = (c == CH_EQ) ? K_LEQUAL : K_ASSIGN;
                        a_len  = sat_inc(len_reg);
                    end else begin
                        a_kind = K_LESS;
                        a_len  = len_reg;
                    end
                    mode_next = M_IDLE;
                end
                M_LITERAL: begin
                    used = 1'b1;
                    if (c == CH_QUOTE) begin
                        a_emit    = 1'b1;
                        a_kind    = K_LITERAL;
                        a_len     = len_reg;
                        a_colinc  = 1'b1;
                        mode_next = M_IDLE;
                    end else if (c == CH_NUL) begin
                        used      = 1'b0;
                        a_emit    = 1'b1;
                        a_kind    = K_ERROR;
                        a_len     = len_reg;
                        mode_next = M_IDLE;
                    end else begin
                        len_next = sat_inc(len_next);
                    end
                end
                default: begin
                    mode_next = M_IDLE;
                end
            endcase
        end

        a_line = line_next;
        a_col  = col_next;
        if (a_emit) begin
            col_next = sat_add(col_next, a_len);
        end
        if (a_colinc) begin
            col_next = sat_inc(col_next);
        end

        // the byte that ended the held token starts what follows
        if (!used) begin
            if (c == CH_NUL) begin
                ended_next = 1'b1;
                b_emit     = 1'b1;
                b_kind     = K_END;
            end else if (c == CH_SPACE || c == CH_CR || c == CH_TAB) begin
                col_next = sat_inc(col_next);
            end else if (c == CH_LF) begin
                if (line_next != LINE_TOP) begin
                    line_next = line_next + LINE_BITS'(1);
                end
                col_next = COL_BITS'(1);
            end else if (c == CH_HASH) begin
                col_next  = sat_inc(col_next);
                mode_next = M_COMMENT;
            end else if (c == CH_QUOTE) begin
                col_next  = sat_inc(col_next);
                mode_next = M_LITERAL;
                len_next  = '0;
            end else if (pk != K_END) begin
                b_emit = 1'b1;
                b_kind = pk;
                b_len  = LEN_BITS'(1);
            end else if (c == CH_DOT || c == CH_COLON || c == CH_LT || c == CH_GT
                         || is_digit(c) || is_alpha(c)) begin
                mode_next = (c == CH_DOT)   ? M_DOT :
                            (c == CH_COLON) ? M_COLON :
                            (c == CH_LT)    ? M_LESS :
                            (c == CH_GT)    ? M_GREATER :
                            is_digit(c)     ? M_INT : M_IDENT;
                len_next  = LEN_BITS'(1);
                pfx_next  = {{(KW_BITS-8){1'b0}}, c};
            end else begin
                b_emit = 1'b1;
                b_kind = K_ERROR;
                b_len  = LEN_BITS'(1);
            end
        end

        b_line = line_next;
        b_col  = col_next;
        if (b_emit) begin
            col_next = sat_add(col_next, b_len);
        end
    end

    // grow() of the identifier prefix in the held-token modes
    logic [KW_BITS-1:0] pfx_grown;
    assign pfx_grown = grow_pfx(pfx_reg, len_reg, c);

    logic grow_pfx_en;
    assign grow_pfx_en = !ended_reg && used && !a_emit && !a_colinc
                         && mode_reg != M_LITERAL && mode_reg != M_COMMENT;

    always_comb begin
        res.count = {1'b0, a_emit} + {1'b0, b_emit};
        res.tok0  = a_emit ? token_t'{a_kind, a_line, a_col, a_len, a_kw, !b_emit}
                           : token_t'{b_kind, b_line, b_col, b_len, KW_IDX_BITS'(0), 1'b1};
        res.tok1  = token_t'{b_kind, b_line, b_col, b_len, KW_IDX_BITS'(0), 1'b1};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            line_reg  <= LINE_BITS'(1);
            col_reg   <= COL_BITS'(1);
            len_reg   <= '0;
            pfx_reg   <= '0;
            ended_reg <= 1'b0;
        end else if (in_fire) begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            len_reg   <= len_next;
            pfx_reg   <= (grow_pfx_en && mode_next == mode_reg) || mode_next == M_FRAC
                         || mode_next == M_EXP || mode_next == M_SIGN || mode_next == M_EXPD
                         ? pfx_grown : pfx_next;
            ended_reg <= ended_next;
        end
    end

endmodule

`default_nettype wire

// ===== verif/etok_token_checker.sv =====
`timescale 1ns / 1ps

module etok_token_checker
    import etok_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [71:0] m_tdata,
    input  wire logic        m_tlast,
    input  wire logic        cfg_wr_en,
    input  wire logic [3:0]  cfg_addr,
    input  wire logic [63:0] cfg_wdata,
    output int               fail_count,
    output int               pending,
    output int               tokens_checked
);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    localparam int LINE_LSB = KIND_BITS;
    localparam int COL_LSB  = LINE_LSB + LINE_BITS;
    localparam int LEN_LSB  = COL_LSB + COL_BITS;
    localparam int KW_LSB   = LEN_LSB + LEN_BITS;
    localparam int PAD_LSB  = KW_LSB + KW_IDX_BITS;

    localparam int MAX_REPORTS = 20;

    scan_mode_t             mode;
    logic [LINE_BITS-1:0]   line_no;
    logic [COL_BITS-1:0]    col_no;
    logic [LEN_BITS-1:0]    tok_len;
    logic [KW_BITS-1:0]     word_prefix;
    logic                   text_done;
    logic [KW_BITS-1:0]     slots [KEYWORD_COUNT];
    token_t                 step_toks [$];
    token_t                 expected_tokens [$];

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [KIND_BITS-1:0] punct_kind(input logic [7:0] c);
        case (c)
            "+": return K_PLUS;
            "-": return K_MINUS;
            "*": return K_STAR;
            "/": return K_SLASH;
            "^": return K_CARET;
            "|": return K_PIPE;
            "&": return K_AMP;
            "!": return K_BANG;
            "=": return K_EQUAL;
            "(": return K_LPAREN;
            ")": return K_RPAREN;
            "[": return K_LBRACK;
            "]": return K_RBRACK;
            "{": return K_LBRACE;
            "}": return K_RBRACE;
            ",": return K_COMMA;
            ";": return K_SEMI;
            default: return K_ERROR;
        endcase
    endfunction

    task automatic advance_col();
        if (col_no != '1) col_no++;
    endtask

    task automatic push_token(input logic [KIND_BITS-1:0] kind, input logic [LEN_BITS-1:0] len,
                              input logic [KW_IDX_BITS-1:0] kw);
        token_t            t;
        logic [COL_BITS:0] sum;
        t.kind = kind;
        t.line = line_no;
        t.col  = col_no;
        t.len  = len;
        t.kw   = kw;
        t.last = 1'b0;
        step_toks.push_back(t);
        // the column moves past the token and sticks at its ceiling
        sum = col_no + len;
        col_no = sum[COL_BITS] ? '1 : sum[COL_BITS-1:0];
    endtask

    task automatic grow_token(input logic [7:0] c);
        if (tok_len < KEYWORD_CHARS) word_prefix[8*tok_len +: 8] = c;
        if (tok_len != '1) tok_len++;
    endtask

    task automatic open_token(input scan_mode_t m, input logic [7:0] c);
        mode = m;
        tok_len = '0;
        word_prefix = '0;
        grow_token(c);
    endtask

    task automatic emit_word();
        int hit;
        int i;
        hit = -1;
        // walk downward so the lowest matching slot wins
        if (tok_len <= KEYWORD_CHARS)
            for (i = KEYWORD_COUNT - 1; i >= 0; i--)
                if (slots[i] != '0 && slots[i] == word_prefix) hit = i;
        if (hit >= 0) push_token(K_KEYWORD, tok_len, hit[KW_IDX_BITS-1:0]);
        else push_token(K_IDENT, tok_len, '0);
    endtask

    task automatic scan_fresh(input logic [7:0] c);
        logic [KIND_BITS-1:0] pk;
        pk = punct_kind(c);
        if (c == CH_NUL) begin
            text_done = 1'b1;
            push_token(K_END, '0, '0);
        end else if (c == " " || c == CH_TAB || c == CH_CR) begin
            advance_col();
        end else if (c == CH_LF) begin
            if (line_no != '1) line_no++;
            col_no = 1;
        end else if (c == "#") begin
            advance_col();
            mode = M_COMMENT;
        end else if (c == CH_QUOTE) begin
            advance_col();
            mode = M_LITERAL;
            tok_len = '0;
        end else if (pk != K_ERROR) begin
            push_token(pk, 1, '0);
        end else if (c == ".") begin
            open_token(M_DOT, c);
        end else if (c == ":") begin
            open_token(M_COLON, c);
        end else if (c == "<") begin
            open_token(M_LESS, c);
        end else if (c == ">") begin
            open_token(M_GREATER, c);
        end else if (is_digit(c)) begin
            open_token(M_INT, c);
        end else if (is_alpha(c)) begin
            open_token(M_IDENT, c);
        end else begin
            push_token(K_ERROR, 1, '0);
        end
    endtask

    task automatic predict_scan(input logic [7:0] data, input logic eoi);
        logic [7:0]           c;
        logic [7:0]           want;
        logic                 used;
        logic [KIND_BITS-1:0] short_k;
        logic [KIND_BITS-1:0] long_k;
        token_t               tail;
        c = eoi ? CH_NUL : data;
        used = 1'b0;
        step_toks.delete();
        if (text_done) begin
            push_token(K_END, '0, '0);
        end else begin
            case (mode)
                M_COMMENT: begin
                    if (c != CH_NUL && c != CH_LF) begin
                        advance_col();
                        used = 1'b1;
                    end else begin
                        mode = M_IDLE;
                    end
                end
                M_IDENT: begin
                    if (is_alpha(c) || is_digit(c) || c == "_") begin
                        grow_token(c);
                        used = 1'b1;
                    end else begin
                        emit_word();
                        mode = M_IDLE;
                    end
                end
                M_INT, M_FRAC: begin
                    used = 1'b1;
                    if (is_digit(c)) begin
                        grow_token(c);
                    end else if (c == "." && mode == M_INT) begin
                        grow_token(c);
                        mode = M_FRAC;
                    end else if (c == "e" || c == "E") begin
                        grow_token(c);
                        mode = M_EXP;
                    end else begin
                        used = 1'b0;
                        push_token(mode == M_INT ? K_INTEGER : K_NUMBER, tok_len, '0);
                        mode = M_IDLE;
                    end
                end
                M_EXP, M_SIGN: begin
                    used = 1'b1;
                    if (is_digit(c)) begin
                        grow_token(c);
                        mode = M_EXPD;
                    end else if (mode == M_EXP && (c == "-" || c == "+")) begin
                        grow_token(c);
                        mode = M_SIGN;
                    end else begin
                        // exponent with no digits: the whole lexeme is an error
                        used = 1'b0;
                        push_token(K_ERROR, tok_len, '0);
                        mode = M_IDLE;
                    end
                end
                M_EXPD: begin
                    if (is_digit(c)) begin
                        grow_token(c);
                        used = 1'b1;
                    end else begin
                        push_token(K_NUMBER, tok_len, '0);
                        mode = M_IDLE;
                    end
                end
                M_DOT, M_COLON, M_GREATER: begin
                    want = (mode == M_DOT) ? "." : "=";
                    short_k = (mode == M_DOT) ? K_DOT : (mode == M_COLON) ? K_COLON : K_GREATER;
                    long_k = (mode == M_DOT) ? K_DOTS : (mode == M_COLON) ? K_DEFINE : K_GEQUAL;
                    if (c == want) begin
                        grow_token(c);
                        used = 1'b1;
                        push_token(long_k, tok_len, '0);
                    end else begin
                        push_token(short_k, tok_len, '0);
                    end
                    mode = M_IDLE;
                end
                M_LESS: begin
                    if (c == "=" || c == "-") begin
                        grow_token(c);
                        used = 1'b1;
                        push_token(c == "=" ? K_LEQUAL : K_ASSIGN, tok_len, '0);
                    end else begin
                        push_token(K_LESS, tok_len, '0);
                    end
                    mode = M_IDLE;
                end
                M_LITERAL: begin
                    used = 1'b1;
                    if (c == CH_QUOTE) begin
                        push_token(K_LITERAL, tok_len, '0);
                        advance_col();
                        mode = M_IDLE;
                    end else if (c == CH_NUL) begin
                        used = 1'b0;
                        push_token(K_ERROR, tok_len, '0);
                        mode = M_IDLE;
                    end else if (tok_len != '1) begin
                        tok_len++;
                    end
                end
                default: mode = M_IDLE;
            endcase
            // the byte that closed a held token starts the next one
            if (!used) scan_fresh(c);
        end
        if (step_toks.size() > 0) begin
            tail = step_toks.pop_back();
            tail.last = 1'b1;
            step_toks.push_back(tail);
        end
        foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
    endtask

    always @(posedge aclk) begin
        token_t got;
        token_t want_tok;
        if (!aresetn) begin
            mode = M_IDLE;
            line_no = 1;
            col_no = 1;
            tok_len = '0;
            word_prefix = '0;
            text_done = 1'b0;
            foreach (slots[i]) slots[i] = '0;
            expected_tokens.delete();
        end else begin
            if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
                got.kind = m_tdata[LINE_LSB-1:0];
                got.line = m_tdata[COL_LSB-1:LINE_LSB];
                got.col  = m_tdata[LEN_LSB-1:COL_LSB];
                got.len  = m_tdata[KW_LSB-1:LEN_LSB];
                got.kw   = m_tdata[PAD_LSB-1:KW_LSB];
                got.last = m_tlast;
                if (expected_tokens.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t ns: token beat with none expected, got kind=%0d line=%0d",
                                 $time, got.kind, got.line,
                                 " col=%0d len=%0d kw=%0d last=%0b",
                                 got.col, got.len, got.kw, got.last);
                end else begin
                    want_tok = expected_tokens.pop_front();
                    tokens_checked++;
                    if (got !== want_tok || m_tdata[71:PAD_LSB] !== '0) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t ns: token %0d mismatch, expected kind=%0d line=%0d",
                                     $time, tokens_checked, want_tok.kind, want_tok.line,
                                     " col=%0d len=%0d kw=%0d last=%0b pad=0",
                                     want_tok.col, want_tok.len, want_tok.kw, want_tok.last,
                                     ", got kind=%0d line=%0d col=%0d len=%0d kw=%0d",
                                     got.kind, got.line, got.col, got.len, got.kw,
                                     " last=%0b pad=%0h", got.last, m_tdata[71:PAD_LSB]);
                    end
                end
            end

            if (s_tvalid === 1'b1 && s_tready === 1'b1) predict_scan(s_tdata, s_tuser);

            // a slot written at this edge applies from the next beat on
            if (cfg_wr_en && cfg_addr < KEYWORD_COUNT) slots[cfg_addr[2:0]] = cfg_wdata;
        end
        pending = expected_tokens.size();
    end

endmodule

// ===== verif/tb_expression_tokenizer.sv =====
`timescale 1ns / 1ps

module tb_expression_tokenizer;
    import etok_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_BYTES  = 240;
    localparam int STALL_CYCLES  = 400;
    localparam int RUN_LIMIT_NS  = 10_000_000;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [3:0]  cfg_addr  = '0;
    logic [63:0] cfg_wdata = '0;

    int fail_count;
    int pending;
    int tokens_checked;
    int src_idle_pct   = 0;
    int dst_idle_pct   = 0;
    int stall_requests = 0;
    int bytes_sent     = 0;

    string word_pool [10] = '{"if", "then", "else", "while", "for", "end", "function",
                              "x", "If", "do"};
    string operator_pool [26] = '{".", "..", ":", ":=", "<", "<=", "<-", ">", ">=",
                                  "+", "-", "*", "/", "^", "|", "&", "!", "=",
                                  "(", ")", "[", "]", "{", "}", ",", ";"};
    string junk_chars = "$@?~'\\%_";

    expression_tokenizer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    etok_token_checker token_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .fail_count     (fail_count),
        .pending        (pending),
        .tokens_checked (tokens_checked)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // result side: random backpressure, plus long hold-offs on request
    initial begin : token_sink
        int hold_left;
        int seen_requests;
        hold_left = 0;
        seen_requests = 0;
        forever begin
            @(negedge aclk);
            if (stall_requests != seen_requests) begin
                seen_requests = stall_requests;
                hold_left = STALL_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= dst_idle_pct);
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Timed out with %0d tokens still expected", pending);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [63:0] pack_word(input string w);
        logic [63:0] v;
        int i;
        v = '0;
        for (i = 0; i < w.len() && i < KEYWORD_CHARS; i++) v[8*i +: 8] = w[i];
        return v;
    endfunction

    function automatic logic [7:0] rand_alpha();
        return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(9));
    endfunction

    function automatic logic [7:0] literal_byte();
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        if (b == CH_QUOTE) b = CH_LF;
        return b;
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken,
    // with tvalid still high so the next call can keep it up without a glitch
    task automatic send_byte(input logic [7:0] b, input logic eoi = 1'b0);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= eoi;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        wait (pending == 0);
        // a held token produces nothing, so give the block time to settle
        repeat (4) @(negedge aclk);
    endtask

    task automatic program_keywords(input logic [63:0] k0, k1, k2, k3, k4, k5, k6, k7);
        logic [63:0] vals [8];
        int i;
        vals = '{k0, k1, k2, k3, k4, k5, k6, k7};
        for (i = 0; i < 8; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= 4'(i);
            cfg_wdata <= vals[i];
            @(negedge aclk);
        end
        // out-of-range index must not alias onto a slot
        cfg_addr  <= 4'(8 + $urandom_range(7));
        cfg_wdata <= pack_word("x");
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_word();
        int n;
        int i;
        if ($urandom_range(1)) begin
            send_text(word_pool[$urandom_range(9)]);
            // sometimes stretch a keyword past its match
            if ($urandom_range(3) == 0) send_byte($urandom_range(1) ? "_" : rand_digit());
        end else begin
            n = $urandom_range(1, 12);
            send_byte(rand_alpha());
            for (i = 1; i < n; i++)
                case ($urandom_range(5))
                    0: send_byte("_");
                    1: send_byte(rand_digit());
                    default: send_byte(rand_alpha());
                endcase
        end
    endtask

    task automatic send_number();
        repeat ($urandom_range(1, 5)) send_byte(rand_digit());
        if ($urandom_range(1)) begin
            send_byte(".");
            repeat ($urandom_range(3)) send_byte(rand_digit());
        end
        if ($urandom_range(2) == 0) begin
            send_byte($urandom_range(1) ? "e" : "E");
            case ($urandom_range(2))
                0: send_byte("+");
                1: send_byte("-");
                default: ;
            endcase
            repeat ($urandom_range(3)) send_byte(rand_digit());
        end
    endtask

    task automatic send_literal();
        send_byte(CH_QUOTE);
        repeat ($urandom_range(10)) send_byte($urandom_range(7) == 0 ? CH_LF : literal_byte());
        send_byte(CH_QUOTE);
    endtask

    task automatic send_comment();
        logic [7:0] b;
        send_byte("#");
        repeat ($urandom_range(8)) begin
            b = 8'($urandom_range(1, 255));
            send_byte(b == CH_LF ? 8'(" ") : b);
        end
        send_byte(CH_LF);
    endtask

    task automatic send_junk();
        case ($urandom_range(3))
            0: send_byte(8'($urandom_range(128, 255)));
            1: send_byte(junk_chars[$urandom_range(junk_chars.len() - 1)]);
            2: send_byte(8'h7F);
            default: send_byte(8'($urandom_range(1, 8)));
        endcase
    endtask

    task automatic send_separator();
        case ($urandom_range(7))
            0: ;
            1: send_byte(CH_TAB);
            2: send_byte(CH_CR);
            3: send_byte(CH_LF);
            default: send_byte(" ");
        endcase
    endtask

    task automatic send_operator();
        send_text(operator_pool[$urandom_range(25)]);
    endtask

    // mostly well-formed tokens, adjacent or separated, with some raw noise
    task automatic send_source(input int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5: send_word();
                6, 7, 8, 9:       send_number();
                10, 11, 12, 13:   send_operator();
                14:               send_literal();
                15:               send_comment();
                16:               send_junk();
                default:          send_byte(8'($urandom_range(1, 255)));
            endcase
            send_separator();
        end
    endtask

    initial begin : stimulus
        string ending;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        program_keywords(pack_word("if"), pack_word("then"), pack_word("else"),
                         pack_word("while"), pack_word("for"), pack_word("end"),
                         pack_word("function"), pack_word("if"));

        // directed: operators, numbers, bad exponent, literal with newline, comment,
        // high and unknown bytes, eight- and nine-char words
        send_text("if (x1_ 2.e-7:=\"q\n\"#z\n..<-<=>=");
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'h01);
        send_text("1e+x function functions ");

        src_idle_pct = 11;
        dst_idle_pct = 85;
        send_source(RANDOM_BYTES);
        wait_idle();

        program_keywords(pack_word("x"), '1, pack_word("If"), pack_word("do"),
                         pack_word("x"), pack_word("whiles"), '0, pack_word("function"));
        src_idle_pct = 85;
        dst_idle_pct = 11;
        send_source(RANDOM_BYTES);
        wait_idle();

        program_keywords('0, '0, '0, '0, '0, '0, '0, '0);
        src_idle_pct = 0;
        dst_idle_pct = 0;
        // hold the result side while bytes keep coming, so the input stalls
        stall_requests++;
        send_source(RANDOM_BYTES);
        send_text(" a+b :=9 ");

        case ($urandom_range(3))
            0: begin
                ending = "zero byte inside an open literal";
                send_text("\"ab");
                send_byte(CH_NUL);
            end
            1: begin
                ending = "end of input after an identifier";
                send_text("abc");
                send_byte(8'($urandom_range(1, 255)), 1'b1);
            end
            2: begin
                ending = "zero byte after an integer";
                send_text("12");
                send_byte(CH_NUL);
            end
            default: begin
                ending = "end of input between tokens";
                send_byte(8'($urandom_range(255)), 1'b1);
            end
        endcase
        // every later beat must give a lone end token
        repeat (6) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        wait_idle();
        repeat (10) @(posedge aclk);

        $display("Scanned %0d bytes into %0d checked tokens across three keyword sets,",
                 bytes_sent, tokens_checked);
        $display("a long result-side hold-off and a %s", ending);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
